>>> src/tdf_pkg.sv
`default_nettype none

package tdf_pkg;

  // Result slots per input item; the last slot takes whatever is left over.
  localparam int MAX_RESULTS   = 30;
  localparam int CNT_W         = $clog2(MAX_RESULTS);
  localparam int FIRST_DIVISOR = 2;

  // Microprogram addresses
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE    = 4'd0;
  localparam step_t STEP_CHECK   = 4'd1;
  localparam step_t STEP_TRY     = 4'd2;
  localparam step_t STEP_DWAIT   = 4'd3;
  localparam step_t STEP_TEST    = 4'd4;
  localparam step_t STEP_REMZ    = 4'd5;
  localparam step_t STEP_SLOT    = 4'd6;
  localparam step_t STEP_EMIT_D  = 4'd7;
  localparam step_t STEP_INC     = 4'd8;
  localparam step_t STEP_E_PRIME = 4'd9;
  localparam step_t STEP_E_FULL  = 4'd10;
  localparam step_t STEP_E_ERR   = 4'd11;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_DIV_START,
    OP_EMIT_DIV,
    OP_INC_DIV,
    OP_EMIT_PRIME,
    OP_EMIT_FULL,
    OP_EMIT_ERR
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_SMALL,
    COND_DIV_DONE,
    COND_NO_DIV,
    COND_REM_NZ,
    COND_LAST_SLOT,
    COND_OUT_FREE
  } cond_t;

  // NEXT: fall through. JUMP: cond ? target : next. WAIT: cond ? target : stay.
  typedef enum logic [1:0] {
    BR_NEXT,
    BR_JUMP,
    BR_WAIT
  } br_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    br_t   br;
    step_t target;
    logic  take_in;
  } cw_t;

  typedef struct packed {
    logic in_valid;
    logic small_val;
    logic div_done;
    logic no_div;
    logic rem_nz;
    logic last_slot;
    logic out_free;
  } status_t;

  typedef struct packed {
    cw_t  cw;
    logic fire;
  } ctrl_t;

endpackage

`default_nettype wire

>>> src/tdf_ifs.sv
`default_nettype none

interface tdf_in_if #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface tdf_out_if #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] factor;
  logic                  last;
  logic                  error;

  modport source (output valid, output factor, output last, output error, input ready);
  modport sink   (input valid, input factor, input last, input error, output ready);
endinterface

`default_nettype wire

>>> src/trial_division_factorizer.sv
`default_nettype none

// Channel  Dir  Payload                          Handshake
// in_ch    in   number[VALUE_BITS-1:0]           valid/ready
// out_ch   out  factor[VALUE_BITS-1:0],last,error valid/ready
//
// One item at a time. Each trial divisor costs one serial division in the
// divider plus a pass through the sequencer steps; a prime near 2^31 tries
// some 46 000 divisors. The shared divider sets the run time.
// Reset (rst_n, synchronous) returns the sequencer to idle and empties the
// output register. A stalled out_ch holds the sequencer at its emit step;
// the next item is taken while the final result still waits in out_ch.
module trial_division_factorizer import tdf_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  tdf_in_if.sink    in_ch,
  tdf_out_if.source out_ch
);

  // divisor never passes sqrt(2^VALUE_BITS) + 1
  localparam int DIV_BITS = VALUE_BITS / 2 + 1;

  ctrl_t   ctrl;
  status_t status;

  // working state
  logic [VALUE_BITS-1:0] rem_val_r;   // remaining value
  logic [DIV_BITS-1:0]   divisor_r;   // trial divisor
  logic [CNT_W-1:0]      count_r;     // results emitted for this item

  // output register
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] factor_r;
  logic                  last_r;
  logic                  error_r;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIV_BITS-1:0]   div_rem;
  logic [VALUE_BITS-1:0] divisor_ext;
  logic                  emit;

  assign divisor_ext = {{(VALUE_BITS - DIV_BITS){1'b0}}, divisor_r};

  tdf_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  tdf_divider #(
    .VALUE_BITS (VALUE_BITS),
    .DIV_BITS   (DIV_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_val_r),
    .divisor  (divisor_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // flags for the sequencer's conditional branches
  assign status.in_valid  = in_ch.valid;
  assign status.small_val = (rem_val_r[VALUE_BITS-1:1] == '0);
  assign status.div_done  = div_done;
  // divisor above remaining/divisor: no divisor up to the square root, so prime
  assign status.no_div    = (divisor_ext > div_quot);
  assign status.rem_nz    = (div_rem != '0);
  assign status.last_slot = (count_r == CNT_W'(MAX_RESULTS - 1));
  assign status.out_free  = !out_valid_r || out_ch.ready;

  assign in_ch.ready = ctrl.cw.take_in;
  assign div_start   = ctrl.fire && (ctrl.cw.op == OP_DIV_START);

  assign emit = ctrl.fire && ((ctrl.cw.op == OP_EMIT_DIV) || (ctrl.cw.op == OP_EMIT_PRIME) ||
                              (ctrl.cw.op == OP_EMIT_FULL) || (ctrl.cw.op == OP_EMIT_ERR));

  // datapath: one op per fired step
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      unique case (ctrl.cw.op)
        OP_ACCEPT: begin
          rem_val_r <= in_ch.number;
          divisor_r <= DIV_BITS'(FIRST_DIVISOR);
          count_r   <= '0;
        end
        OP_EMIT_DIV: begin
          factor_r  <= divisor_ext;
          last_r    <= 1'b0;
          error_r   <= 1'b0;
          rem_val_r <= div_quot;
          count_r   <= count_r + CNT_W'(1);
        end
        OP_INC_DIV: begin
          divisor_r <= divisor_r + DIV_BITS'(1);
        end
        OP_EMIT_PRIME: begin
          factor_r <= rem_val_r;
          last_r   <= 1'b1;
          error_r  <= 1'b0;
        end
        // out of result slots with factors left: hand back the remainder, flagged
        OP_EMIT_FULL: begin
          factor_r <= rem_val_r;
          last_r   <= 1'b1;
          error_r  <= 1'b1;
        end
        // input below two
        OP_EMIT_ERR: begin
          factor_r <= '0;
          last_r   <= 1'b1;
          error_r  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.factor = factor_r;
  assign out_ch.last   = last_r;
  assign out_ch.error  = error_r;

endmodule

`default_nettype wire

>>> src/tdf_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tdf_divider import tdf_pkg::*; #(
  parameter int VALUE_BITS = 31,
  parameter int DIV_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0]   divisor,   // held stable by the caller while busy
  output logic                  done,
  output logic [VALUE_BITS-1:0] quot,
  output logic [DIV_BITS-1:0]   rem
);

  localparam int CW = $clog2(VALUE_BITS);

  logic                  busy_r;
  logic                  done_r;
  logic [CW-1:0]         cnt_r;
  logic [VALUE_BITS-1:0] quot_r;
  logic [DIV_BITS-1:0]   rem_r;
  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     diff;
  logic                  fits;

  assign trial = {rem_r, quot_r[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(VALUE_BITS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
    end else if (busy_r) begin
      quot_r <= {quot_r[VALUE_BITS-2:0], fits};
      rem_r  <= fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

>>> src/tdf_sequencer.sv
`default_nettype none

// Step counter plus control store.
module tdf_sequencer import tdf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output ctrl_t   ctrl
);

  step_t upc_r;
  step_t upc_nxt;
  cw_t   cw;
  logic  cond_true;

  // control store: op, condition, branch mode, target, take_in
  always_comb begin
    unique case (upc_r)
      STEP_IDLE:    cw = '{OP_ACCEPT,     COND_IN_VALID,  BR_WAIT, STEP_CHECK,   1'b1};
      STEP_CHECK:   cw = '{OP_NONE,       COND_SMALL,     BR_JUMP, STEP_E_ERR,   1'b0};
      STEP_TRY:     cw = '{OP_DIV_START,  COND_ALWAYS,    BR_NEXT, STEP_IDLE,    1'b0};
      STEP_DWAIT:   cw = '{OP_NONE,       COND_DIV_DONE,  BR_WAIT, STEP_TEST,    1'b0};
      STEP_TEST:    cw = '{OP_NONE,       COND_NO_DIV,    BR_JUMP, STEP_E_PRIME, 1'b0};
      STEP_REMZ:    cw = '{OP_NONE,       COND_REM_NZ,    BR_JUMP, STEP_INC,     1'b0};
      STEP_SLOT:    cw = '{OP_NONE,       COND_LAST_SLOT, BR_JUMP, STEP_E_FULL,  1'b0};
      STEP_EMIT_D:  cw = '{OP_EMIT_DIV,   COND_OUT_FREE,  BR_WAIT, STEP_TRY,     1'b0};
      STEP_INC:     cw = '{OP_INC_DIV,    COND_ALWAYS,    BR_JUMP, STEP_TRY,     1'b0};
      STEP_E_PRIME: cw = '{OP_EMIT_PRIME, COND_OUT_FREE,  BR_WAIT, STEP_IDLE,    1'b0};
      STEP_E_FULL:  cw = '{OP_EMIT_FULL,  COND_OUT_FREE,  BR_WAIT, STEP_IDLE,    1'b0};
      STEP_E_ERR:   cw = '{OP_EMIT_ERR,   COND_OUT_FREE,  BR_WAIT, STEP_IDLE,    1'b0};
      default:      cw = '{OP_NONE,       COND_ALWAYS,    BR_JUMP, STEP_IDLE,    1'b0};
    endcase
  end

  always_comb begin
    unique case (cw.cond)
      COND_ALWAYS:    cond_true = 1'b1;
      COND_IN_VALID:  cond_true = status.in_valid;
      COND_SMALL:     cond_true = status.small_val;
      COND_DIV_DONE:  cond_true = status.div_done;
      COND_NO_DIV:    cond_true = status.no_div;
      COND_REM_NZ:    cond_true = status.rem_nz;
      COND_LAST_SLOT: cond_true = status.last_slot;
      COND_OUT_FREE:  cond_true = status.out_free;
    endcase
  end

  always_comb begin
    unique case (cw.br)
      BR_NEXT: upc_nxt = upc_r + step_t'(1);
      BR_JUMP: upc_nxt = cond_true ? cw.target : upc_r + step_t'(1);
      BR_WAIT: upc_nxt = cond_true ? cw.target : upc_r;
      default: upc_nxt = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= STEP_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // a WAIT step performs its op only on the cycle it leaves
  assign ctrl.cw   = cw;
  assign ctrl.fire = (cw.br != BR_WAIT) || cond_true;

endmodule

`default_nettype wire
